>>> src/ujlt_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the UDP receive jitter and loss tracker.
package ujlt_pkg;

  localparam int SEQ_W      = 63;
  localparam int TIME_W     = 64;
  localparam int LEN_W      = 16;
  localparam int BYTES_W    = 64;
  localparam int CNT_W      = 32;
  localparam int JIT_OUT_W  = 28;
  localparam int JIT_SHIFT  = 4;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_FIN  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [SEQ_W-1:0]        seq_id;
    logic [TIME_W-1:0]       sent_us;
    logic [TIME_W-1:0]       arrival_us;
    logic [LEN_W-1:0]        payload_len;
  } in_req_t;

  typedef struct packed {
    logic [BYTES_W-1:0]      total_bytes;
    logic [CNT_W-1:0]        datagram_count;
    logic [CNT_W-1:0]        lost_count;
    logic [CNT_W-1:0]        out_of_order_count;
    logic [JIT_OUT_W-1:0]    smoothed_jitter;
  } out_req_t;

  // Request as held in the input stage: transit time already formed.
  typedef struct packed {
    logic                    valid;
    cmd_t                    cmd;
    logic [SEQ_W-1:0]        seq_id;
    logic [TIME_W-1:0]       transit;
    logic [LEN_W-1:0]        payload_len;
  } stage_t;

endpackage

>>> src/ujlt_in_stage.sv
`timescale 1ns / 1ps
// Input register: takes a request and stores it with its transit time.
module ujlt_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ujlt_pkg::in_req_t item,
  input  logic              advance,
  output ujlt_pkg::stage_t  stage
);
  import ujlt_pkg::*;

  assign item_ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stage.valid       <= 1'b1;
      stage.cmd         <= item.cmd;
      stage.seq_id      <= item.seq_id;
      stage.transit     <= item.arrival_us - item.sent_us;
      stage.payload_len <= item.payload_len;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
  end

endmodule

>>> src/ujlt_core.sv
`timescale 1ns / 1ps
// Statistics state and the per-request update of bytes, jitter, gaps and loss.
module ujlt_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ujlt_pkg::stage_t   stage,
  output ujlt_pkg::out_req_t stats_next
);
  import ujlt_pkg::*;

  logic [TIME_W-1:0]    last_transit;
  logic                 transit_valid;
  logic [CNT_W-1:0]     jitter_sixteenths;
  logic [SEQ_W:0]       expected_next;
  logic [CNT_W-1:0]     gap_total;
  logic [BYTES_W-1:0]   running_bytes;
  logic [CNT_W-1:0]     running_datagrams;
  logic [CNT_W-1:0]     running_reorders;
  logic [JIT_OUT_W-1:0] running_jitter;

  logic                 transit_valid_next;
  logic [CNT_W-1:0]     jitter_sixteenths_next;
  logic [SEQ_W:0]       expected_next_next;
  logic [CNT_W-1:0]     gap_total_next;
  logic [BYTES_W-1:0]   running_bytes_next;
  logic [CNT_W-1:0]     running_datagrams_next;
  logic [CNT_W-1:0]     running_reorders_next;
  logic [CNT_W-1:0]     running_lost_next;
  logic [JIT_OUT_W-1:0] running_jitter_next;

  logic [TIME_W-1:0]    delta;
  logic [CNT_W-1:0]     delta_mag;
  logic [SEQ_W:0]       seq_ext;
  logic [SEQ_W:0]       gap;
  logic [CNT_W-1:0]     gap_sat;
  logic [SEQ_W-1:0]     fin_expect;
  logic                 seq_ge;
  logic                 seq_gt;

  always_comb begin
    seq_ext = {1'b0, stage.seq_id};
    seq_ge  = seq_ext >= expected_next;
    seq_gt  = seq_ext > expected_next;
    gap     = seq_ext - expected_next;
    gap_sat = (|gap[SEQ_W:CNT_W]) ? '1 : gap[CNT_W-1:0];

    // Only the low word of |delta| feeds the jitter register.
    delta     = stage.transit - last_transit;
    delta_mag = delta[TIME_W-1] ? (CNT_W'(0) - delta[CNT_W-1:0]) : delta[CNT_W-1:0];

    fin_expect = (stage.seq_id == '0) ? '0 : (stage.seq_id - SEQ_W'(1));

    transit_valid_next     = transit_valid;
    jitter_sixteenths_next = jitter_sixteenths;
    expected_next_next     = expected_next;
    gap_total_next         = gap_total;
    running_bytes_next     = running_bytes;
    running_datagrams_next = running_datagrams;
    running_reorders_next  = running_reorders;
    running_jitter_next    = running_jitter;

    unique case (stage.cmd)
      CMD_DATA: begin
        running_bytes_next     = running_bytes + BYTES_W'(stage.payload_len);
        running_datagrams_next = running_datagrams + CNT_W'(1);
        transit_valid_next     = 1'b1;
        if (transit_valid) begin
          jitter_sixteenths_next = jitter_sixteenths + delta_mag
                                   - (jitter_sixteenths >> JIT_SHIFT);
          running_jitter_next    = JIT_OUT_W'(jitter_sixteenths_next >> JIT_SHIFT);
        end
        if (seq_ge) begin
          gap_total_next     = gap_total + gap_sat;
          expected_next_next = seq_ext + (SEQ_W+1)'(1);
        end else begin
          running_reorders_next = running_reorders + CNT_W'(1);
        end
      end
      CMD_FIN: begin
        if (seq_gt) begin
          gap_total_next     = gap_total + gap_sat;
          expected_next_next = seq_ext;
        end
        running_datagrams_next = (|fin_expect[SEQ_W-1:CNT_W]) ? '1 : fin_expect[CNT_W-1:0];
      end
      default: ;
    endcase

    running_lost_next = (gap_total_next > running_reorders_next)
                        ? (gap_total_next - running_reorders_next) : '0;

    stats_next.total_bytes        = running_bytes_next;
    stats_next.datagram_count     = running_datagrams_next;
    stats_next.lost_count         = running_lost_next;
    stats_next.out_of_order_count = running_reorders_next;
    stats_next.smoothed_jitter    = running_jitter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_transit      <= '0;
      transit_valid     <= 1'b0;
      jitter_sixteenths <= '0;
      expected_next     <= '0;
      gap_total         <= '0;
      running_bytes     <= '0;
      running_datagrams <= '0;
      running_reorders  <= '0;
      running_jitter    <= '0;
    end else if (fire) begin
      if (stage.cmd == CMD_DATA) begin
        last_transit <= stage.transit;
      end
      transit_valid     <= transit_valid_next;
      jitter_sixteenths <= jitter_sixteenths_next;
      expected_next     <= expected_next_next;
      gap_total         <= gap_total_next;
      running_bytes     <= running_bytes_next;
      running_datagrams <= running_datagrams_next;
      running_reorders  <= running_reorders_next;
      running_jitter    <= running_jitter_next;
    end
  end

endmodule

>>> src/udp_rx_jitter_loss_tracker_unit.sv
`timescale 1ns / 1ps
// Top level of the UDP receive jitter and loss tracker.
//
// Input channel item_valid/item_ready/item carries one request per datagram
// event: a data datagram (sequence id, send and receive times, length) or a
// FIN with the id that follows the last data datagram. Output channel
// result_valid/result_ready/result returns one request per input request with
// the running byte total, datagram count, lost and out-of-order counts and
// smoothed jitter in microseconds.
// Path: the input register loads at the accepting edge; the result register
// loads from it when the result side can take a result, and offers it.
// Throughput: one request per cycle while result_ready keeps the result side
// moving; the state update for a request is combinational.
// Reset (rst, synchronous) clears all statistics, drops any request in flight
// and leaves the block ready at once.
// When result_ready is low the result register holds and the input register
// fills; item_ready drops only when both are occupied.
module udp_rx_jitter_loss_tracker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ujlt_pkg::in_req_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output ujlt_pkg::out_req_t result
);
  import ujlt_pkg::*;

  stage_t   stage;
  out_req_t stats_next;
  logic     advance;
  logic     fire;

  assign advance = !result_valid || result_ready;
  assign fire    = stage.valid && advance;

  ujlt_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .advance    (advance),
    .stage      (stage)
  );

  ujlt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .stage      (stage),
    .stats_next (stats_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= stats_next;
    end
  end

endmodule

>>> src/ujlt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tracker, bound to the top level.
module ujlt_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input ujlt_pkg::out_req_t result
);
  import ujlt_pkg::*;

  // Reset empties both registers.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && item_ready))
    else $error("block not empty after reset");

  // With no result pending the input side can never be blocked.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item_ready low with empty result register");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("result changed while stalled");

  // The input side is only blocked by a stalled result.
  a_block_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("item_ready low without a stalled result");

endmodule

bind udp_rx_jitter_loss_tracker_unit ujlt_checker u_ujlt_checker (.*);

>>> test/udp_rx_jitter_loss_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UDP receive jitter and loss tracker: random stalls, checks.
module udp_rx_jitter_loss_tracker_unit_tb;
  import ujlt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 700;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  in_req_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  out_req_t result;

  in_req_t  dgram_queue[$];
  out_req_t stats_due[$];
  int       errors = 0;
  int       accepted = 0;
  int       checked = 0;
  int       cycles = 0;
  int       hold_left = 0;

  // expected tracker state
  logic [63:0] prev_transit = '0;
  bit          have_transit = 1'b0;
  logic [31:0] jit16 = '0;
  logic [63:0] next_id = '0;
  logic [31:0] gap_sum = '0;
  logic [63:0] byte_sum = '0;
  logic [31:0] dgram_cnt = '0;
  logic [31:0] reorder_cnt = '0;

  udp_rx_jitter_loss_tracker_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic out_req_t next_stats(input in_req_t r);
    logic [63:0] seq64;
    logic [63:0] transit;
    logic [63:0] delta;
    out_req_t    o;
    seq64 = {1'b0, r.seq_id};
    if (r.cmd == CMD_DATA) begin
      transit = r.arrival_us - r.sent_us;
      byte_sum = byte_sum + 64'(r.payload_len);
      dgram_cnt = dgram_cnt + 32'd1;
      if (have_transit) begin
        delta = transit - prev_transit;
        if (delta[63]) delta = 64'd0 - delta;
        jit16 = jit16 + delta[31:0] - (jit16 >> JIT_SHIFT);
      end
      prev_transit = transit;
      have_transit = 1'b1;
      if (seq64 >= next_id) begin
        gap_sum = gap_sum + clamp32(seq64 - next_id);
        next_id = seq64 + 64'd1;
      end else begin
        reorder_cnt = reorder_cnt + 32'd1;
      end
    end else begin
      if (seq64 > next_id) begin
        gap_sum = gap_sum + clamp32(seq64 - next_id);
        next_id = seq64;
      end
      dgram_cnt = clamp32((seq64 != 64'd0) ? seq64 - 64'd1 : 64'd0);
    end
    o.total_bytes        = byte_sum;
    o.datagram_count     = dgram_cnt;
    o.lost_count         = (gap_sum > reorder_cnt) ? gap_sum - reorder_cnt : 32'd0;
    o.out_of_order_count = reorder_cnt;
    o.smoothed_jitter    = JIT_OUT_W'(jit16 >> JIT_SHIFT);
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_req_t data_req(input logic [62:0] id, input logic [63:0] sent,
                                       input logic [63:0] recv, input logic [15:0] len);
    in_req_t r;
    r.cmd         = CMD_DATA;
    r.seq_id      = id;
    r.sent_us     = sent;
    r.arrival_us  = recv;
    r.payload_len = len;
    return r;
  endfunction

  // times and length are don't-care on FIN; randomize them
  function automatic in_req_t fin_req(input logic [62:0] id);
    in_req_t r;
    r.cmd         = CMD_FIN;
    r.seq_id      = id;
    r.sent_us     = rand64();
    r.arrival_us  = rand64();
    r.payload_len = 16'($urandom);
    return r;
  endfunction

  // watchdog, plus one long receiver hold-off to back up the block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == HOLD_START) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver
  int idle_tx = 0;
  bit quiet_tx = 1'b0;
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      item_valid <= 1'b0;
      idle_tx = 0;
    end else begin
      if (item_valid && item_ready) begin
        stats_due.push_back(next_stats(item));
        accepted++;
        if (accepted % 40 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
        idle_tx = quiet_tx ? 0 : $urandom_range(0, 3);
      end
      if (!item_valid || item_ready) begin
        nv = 1'b0;
        if (idle_tx > 0) begin
          idle_tx--;
        end else if (dgram_queue.size() != 0) begin
          item <= dgram_queue.pop_front();
          nv = 1'b1;
        end
        item_valid <= nv;
      end
    end
  end

  // monitor
  int idle_rx = 0;
  bit quiet_rx = 1'b0;
  always @(posedge clk) begin
    out_req_t want;
    logic     rdy;
    if (rst) begin
      result_ready <= 1'b0;
      idle_rx = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (stats_due.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          want = stats_due.pop_front();
          if (result.total_bytes !== want.total_bytes) begin
            $error("total_bytes: expected %0d, got %0d", want.total_bytes, result.total_bytes);
            errors++;
          end
          if (result.datagram_count !== want.datagram_count) begin
            $error("datagram_count: expected %0d, got %0d",
                   want.datagram_count, result.datagram_count);
            errors++;
          end
          if (result.lost_count !== want.lost_count) begin
            $error("lost_count: expected %0d, got %0d", want.lost_count, result.lost_count);
            errors++;
          end
          if (result.out_of_order_count !== want.out_of_order_count) begin
            $error("out_of_order_count: expected %0d, got %0d",
                   want.out_of_order_count, result.out_of_order_count);
            errors++;
          end
          if (result.smoothed_jitter !== want.smoothed_jitter) begin
            $error("smoothed_jitter: expected %0d, got %0d",
                   want.smoothed_jitter, result.smoothed_jitter);
            errors++;
          end
        end
        checked++;
        if (checked % 40 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
        idle_rx = quiet_rx ? 0 : $urandom_range(0, 3);
      end
      rdy = 1'b0;
      if (hold_left != 0) begin
        rdy = 1'b0;
      end else if (idle_rx > 0) begin
        idle_rx--;
      end else begin
        rdy = 1'b1;
      end
      result_ready <= rdy;
    end
  end

  initial begin : stimulus
    logic [63:0] gen_next;
    logic [63:0] now_us;
    logic [63:0] base_lat;
    logic [63:0] lat;
    logic [62:0] id;
    int          roll;

    // directed
    dgram_queue.push_back(fin_req(63'd0));                      // FIN id zero
    dgram_queue.push_back(data_req(63'd0, 64'd0, 64'd0, 16'd0)); // first transit
    dgram_queue.push_back(data_req(63'd1, 64'd0, 64'h8000_0000_0000_0000, 16'hFFFF));
    dgram_queue.push_back(data_req(63'd2, 64'd0, 64'd0, 16'd1)); // most negative delta
    dgram_queue.push_back(data_req(63'd0, 64'd7, 64'd9, 16'd100));   // late
    dgram_queue.push_back(data_req(63'd1, 64'd7, 64'd7, 16'd100));   // late, lost floors
    dgram_queue.push_back(data_req(63'd3, 64'd0, 64'hFFFF_FFFF, 16'd2));
    dgram_queue.push_back(data_req(63'd4, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 16'd3));
    dgram_queue.push_back(data_req(63'd5, 64'd0, 64'hFFFF_FFFF, 16'd4)); // jitter wraps
    dgram_queue.push_back(data_req(63'd6, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                   16'hFFFF));
    dgram_queue.push_back(data_req(63'd10, 64'd100, 64'd50, 16'd5)); // small gap
    dgram_queue.push_back(data_req(63'd10 + (63'd1 << 40), 64'd100, 64'd150, 16'd6));
    dgram_queue.push_back(data_req(63'd20 + (63'd1 << 41), 64'd100, 64'd160, 16'd7));
    dgram_queue.push_back(fin_req(63'd5));                      // FIN below expected
    dgram_queue.push_back(fin_req(63'd30 + (63'd1 << 41)));     // tail gap, count saturates
    dgram_queue.push_back(data_req(63'd30 + (63'd1 << 41), 64'd200, 64'd260, 16'd8));
    dgram_queue.push_back(fin_req(63'd31 + (63'd1 << 41)));     // FIN equal to expected
    dgram_queue.push_back(data_req(63'd31 + (63'd1 << 41), 64'hFFFF_FFFF_FFFF_FFFF,
                                   64'd0, 16'd9));

    // random stream
    gen_next = 64'd32 + (64'd1 << 41);
    now_us   = 64'hFFFF_FFFF_FFF0_0000;
    base_lat = 64'd5000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll   = $urandom_range(0, 99);
      now_us = now_us + 64'($urandom_range(20, 3000));
      if ($urandom_range(0, 49) == 0) base_lat = 64'($urandom_range(0, 100000));
      lat = base_lat + 64'($urandom_range(0, 400));
      if (roll < 4) begin
        gen_next = gen_next + 64'($urandom_range(0, 8));
        dgram_queue.push_back(fin_req(gen_next[62:0]));
      end else if (roll < 12) begin
        id = 63'(gen_next - 64'($urandom_range(1, 24)));
        dgram_queue.push_back(data_req(id, now_us, now_us + lat, 16'($urandom)));
      end else if (roll < 20) begin
        gen_next = gen_next + 64'($urandom_range(1, 40));
        dgram_queue.push_back(data_req(gen_next[62:0], now_us, now_us + lat, 16'($urandom)));
        gen_next = gen_next + 64'd1;
      end else if (roll < 21) begin
        gen_next = gen_next + {24'd0, 8'($urandom_range(1, 255)), $urandom};
        dgram_queue.push_back(data_req(gen_next[62:0], now_us, now_us + lat, 16'($urandom)));
        gen_next = gen_next + 64'd1;
      end else if (roll < 27) begin
        id = 63'(gen_next - 64'($urandom_range(1, 1000)));
        dgram_queue.push_back(data_req(id, rand64(), rand64(), 16'($urandom)));
      end else if (roll < 30) begin
        id = 63'(gen_next - 64'($urandom_range(1, 1000)));
        dgram_queue.push_back(fin_req(id));
      end else begin
        dgram_queue.push_back(data_req(gen_next[62:0], now_us, now_us + lat,
                                       (roll < 33) ? 16'hFFFF : 16'($urandom)));
        gen_next = gen_next + 64'd1;
      end
    end

    // top of the id space, then arbitrary ids
    dgram_queue.push_back(data_req({63{1'b1}}, rand64(), rand64(), 16'($urandom)));
    dgram_queue.push_back(fin_req({63{1'b1}}));
    for (int n = 0; n < 6; n++) begin
      dgram_queue.push_back(data_req(63'(rand64()), rand64(), rand64(), 16'($urandom)));
      dgram_queue.push_back(fin_req(63'(rand64())));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (dgram_queue.size() != 0 || item_valid) @(negedge clk);
    while (stats_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
